[design/assert_macros.svh]
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");

// Condition in one cycle implies the consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[design/altpd_pkg.sv]
// Package: constants and types of the altimeter packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package altpd_pkg;

    localparam logic [7:0]  HDR_BYTE    = 8'h52;  // 'R'
    localparam logic [7:0]  TYPE_A_BYTE = 8'h41;  // 'A'
    localparam logic [7:0]  TYPE_B_BYTE = 8'h42;  // 'B'
    localparam logic [7:0]  TYPE_C_BYTE = 8'h43;  // 'C'

    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_XOR_OUT = 16'hFFFF;

    localparam int POS_W = 6;

    localparam logic [POS_W-1:0] LEN_A = 6'd16;
    localparam logic [POS_W-1:0] LEN_B = 6'd32;
    localparam logic [POS_W-1:0] LEN_C = 6'd48;

    // Byte offsets inside the packet
    localparam logic [POS_W-1:0] POS_HUNT     = 6'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 6'd1;
    localparam logic [POS_W-1:0] POS_VERSION  = 6'd2;
    localparam logic [POS_W-1:0] POS_FRAME    = 6'd3;
    localparam logic [POS_W-1:0] POS_DIST_HI  = 6'd4;
    localparam logic [POS_W-1:0] POS_DIST_LO  = 6'd5;
    localparam logic [POS_W-1:0] POS_STR_HI   = 6'd10;
    localparam logic [POS_W-1:0] POS_STR_LO   = 6'd11;
    localparam logic [POS_W-1:0] POS_STATUS   = 6'd13;

    typedef enum logic [1:0] {
        KIND_A = 2'd0,
        KIND_B = 2'd1,
        KIND_C = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [7:0]  proto_ver;
        logic [7:0]  frame_seq;
        logic [15:0] distance_cm;
        logic [15:0] signal_strength;
        logic        gain_flag;
        logic        no_track_flag;
        logic        fail_flag;
    } t_result;

    // Parser status towards the top level
    typedef struct packed {
        logic at_last;    // next byte closes the packet
        logic res_fire;   // checked result produced by this transfer
    } t_parse_status;

endpackage

`default_nettype wire

[design/altpd_crc.sv]
// CRC-16/X.25 byte update, reflected, eight bit steps unrolled.
`timescale 1ns / 1ps
`default_nettype none

module altpd_crc (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);
    import altpd_pkg::*;

    always_comb begin
        logic [15:0] acc;
        acc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        o_crc = acc;
    end

endmodule

`default_nettype wire

[design/altpd_parser.sv]
// Packet parser: byte position, CRC accumulator and field capture.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module altpd_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [7:0]           i_byte,
    output altpd_pkg::t_result        o_result,
    output altpd_pkg::t_parse_status  o_status
);
    import altpd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_kind            r_kind, n_kind;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_version, n_version;
    logic [7:0]       r_frame, n_frame;
    logic [15:0]      r_dist, n_dist;
    logic [15:0]      r_str, n_str;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_crc_lo, n_crc_lo;

    logic [15:0]      crc_upd;
    logic [POS_W-1:0] len;
    logic             crc_ok;
    logic             res_fire;

    altpd_crc u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        case (r_kind)
            KIND_A:  len = LEN_A;
            KIND_B:  len = LEN_B;
            default: len = LEN_C;
        endcase
    end

    assign crc_ok = ({i_byte, r_crc_lo} == (r_crc ^ CRC_XOR_OUT));

    always_comb begin
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_crc     = r_crc;
        n_version = r_version;
        n_frame   = r_frame;
        n_dist    = r_dist;
        n_str     = r_str;
        n_status  = r_status;
        n_crc_lo  = r_crc_lo;
        res_fire  = 1'b0;
        if (i_fire) begin
            if (r_pos == POS_HUNT) begin
                // accumulator is at its initial value while hunting
                if (i_byte == HDR_BYTE) begin
                    n_crc = crc_upd;
                    n_pos = POS_TYPE;
                end
            end else if (r_pos == POS_TYPE) begin
                if (i_byte == TYPE_A_BYTE || i_byte == TYPE_B_BYTE ||
                    i_byte == TYPE_C_BYTE) begin
                    case (i_byte)
                        TYPE_A_BYTE: n_kind = KIND_A;
                        TYPE_B_BYTE: n_kind = KIND_B;
                        default:     n_kind = KIND_C;
                    endcase
                    n_crc = crc_upd;
                    n_pos = POS_VERSION;
                end else begin
                    n_crc = CRC_INIT;
                    n_pos = POS_HUNT;
                end
            end else if (r_pos < len - 6'd2) begin
                n_crc = crc_upd;
                case (r_pos)
                    POS_VERSION: n_version = i_byte;
                    POS_FRAME:   n_frame = i_byte;
                    POS_DIST_HI: n_dist[15:8] = i_byte;
                    POS_DIST_LO: n_dist[7:0] = i_byte;
                    POS_STR_HI:  n_str[15:8] = i_byte;
                    POS_STR_LO:  n_str[7:0] = i_byte;
                    POS_STATUS:  n_status = {i_byte[3], i_byte[1], i_byte[0]};
                    default:     ;
                endcase
                n_pos = r_pos + 6'd1;
            end else if (r_pos == len - 6'd2) begin
                n_crc_lo = i_byte;
                n_pos    = r_pos + 6'd1;
            end else begin
                res_fire = crc_ok;
                n_crc    = CRC_INIT;
                n_pos    = POS_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HUNT;
            r_kind    <= KIND_A;
            r_crc     <= CRC_INIT;
            r_version <= '0;
            r_frame   <= '0;
            r_dist    <= '0;
            r_str     <= '0;
            r_status  <= '0;
            r_crc_lo  <= '0;
        end else begin
            r_pos     <= n_pos;
            r_kind    <= n_kind;
            r_crc     <= n_crc;
            r_version <= n_version;
            r_frame   <= n_frame;
            r_dist    <= n_dist;
            r_str     <= n_str;
            r_status  <= n_status;
            r_crc_lo  <= n_crc_lo;
        end
    end

    // Kinds B and C carry the kind alone
    always_comb begin
        o_result             = '0;
        o_result.packet_kind = r_kind;
        if (r_kind == KIND_A) begin
            o_result.proto_ver       = r_version;
            o_result.frame_seq       = r_frame;
            o_result.distance_cm     = r_dist;
            o_result.signal_strength = r_str;
            o_result.gain_flag       = r_status[0];
            o_result.no_track_flag   = r_status[1];
            o_result.fail_flag       = r_status[2];
        end
    end

    assign o_status.at_last  = (r_pos >= POS_VERSION) && (r_pos == len - 6'd1);
    assign o_status.res_fire = res_fire;

    `ASSERT_NEVER(a_pos_in_range, i_clk, i_rst_n, r_pos >= LEN_C)
    `ASSERT_NEXT(a_result_rehunts, i_clk, i_rst_n, res_fire, r_pos == POS_HUNT)
    `ASSERT_NEVER(a_pos_within_len, i_clk, i_rst_n, r_pos >= POS_VERSION && r_pos >= len)

endmodule

`default_nettype wire

[design/altpd_out.sv]
// Result register holding one checked packet until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module altpd_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire altpd_pkg::t_result  i_result,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output altpd_pkg::t_result       o_result
);
    import altpd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, i_load && r_valid && i_stall)
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid)
    `ASSERT_NEXT(a_taken_clears, i_clk, i_rst_n, r_valid && !i_stall && !i_load, !r_valid)

endmodule

`default_nettype wire

[design/altimeter_packet_deframer.sv]
// Top level of the altimeter packet deframer.
// One byte is received per transfer, one per unstalled cycle. The block
// hunts for the header 'R', reads the type byte ('A', 'B' or 'C' gives a
// packet of 16, 32 or 48 bytes; any other type byte restarts the hunt with
// the following byte) and runs a CRC-16/X.25 over all but the last two
// bytes, which carry the CRC low byte first. A packet whose CRC matches
// yields one result transfer in the cycle after its last byte; a mismatch
// drops it silently. Kind A results carry version, frame count, distance
// (cm), strength and the gain, no-track and fail flags; kinds B and C carry
// the kind with all other fields zero. The result sits in a single output
// register, so bytes keep flowing while it waits; o_in_stall rises only when
// that register is still held and the waiting byte is the last of a packet.
// The result register drives o_out_valid; the CRC byte update is a
// combinational unrolled step.
`timescale 1ns / 1ps
`default_nettype none

module altimeter_packet_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_packet_kind,
    output logic [7:0]       o_proto_ver,
    output logic [7:0]       o_frame_seq,
    output logic [15:0]      o_distance_cm,
    output logic [15:0]      o_signal_strength,
    output logic             o_gain_flag,
    output logic             o_no_track_flag,
    output logic             o_fail_flag
);
    import altpd_pkg::*;

    t_result       parse_res;
    t_result       out_res;
    t_parse_status parse_st;
    logic          in_fire;

    // hold the closing byte back while the previous result is still unread
    assign o_in_stall = o_out_valid && i_out_stall && parse_st.at_last;
    assign in_fire    = i_in_valid && !o_in_stall;

    altpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_byte   (i_rx_byte),
        .o_result (parse_res),
        .o_status (parse_st)
    );

    altpd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (parse_st.res_fire),
        .i_result (parse_res),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    assign o_packet_kind      = out_res.packet_kind;
    assign o_proto_ver        = out_res.proto_ver;
    assign o_frame_seq        = out_res.frame_seq;
    assign o_distance_cm      = out_res.distance_cm;
    assign o_signal_strength  = out_res.signal_strength;
    assign o_gain_flag        = out_res.gain_flag;
    assign o_no_track_flag    = out_res.no_track_flag;
    assign o_fail_flag        = out_res.fail_flag;

endmodule

`default_nettype wire
